>>> rtl/rtmcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmcw_pkg
// Shared types and constants for the RGB trimmed-mean color window core.
// ----------------------------------------------------------------------------
package rtmcw_pkg;

	localparam int PULSE_BITS_DEF = 16;             // default sample width
	localparam int SAMPLES_PER_CH = 10;             // samples per color channel
	localparam int SMP_W          = $clog2(SAMPLES_PER_CH);
	localparam int TRIM_SHIFT     = 3;              // trimmed sum divided by 8
	localparam int OUT_W          = 17;             // signed average field width
	localparam int CFG_W          = 16;             // window bound width
	localparam int CFG_IDX_W      = 3;
	localparam int OUT_TDATA_W    = ((3 * OUT_W + 1 + 7) / 8) * 8;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_LOW    = 3'd0,
		REG_RED_HIGH   = 3'd1,
		REG_GREEN_LOW  = 3'd2,
		REG_GREEN_HIGH = 3'd3,
		REG_BLUE_LOW   = 3'd4,
		REG_BLUE_HIGH  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] red_low;
		logic [CFG_W-1:0] red_high;
		logic [CFG_W-1:0] green_low;
		logic [CFG_W-1:0] green_high;
		logic [CFG_W-1:0] blue_low;
		logic [CFG_W-1:0] blue_high;
	} window_t;

	// accumulator front end status toward the flow control
	typedef struct packed {
		logic at_frame_end;   // next accepted sample closes the frame
		logic blue_busy;      // a closing blue sample is still in s1/s2
	} acc_stat_t;

endpackage

>>> rtl/rtmcw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmcw_cfg
// Window bound register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module rtmcw_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rtmcw_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [rtmcw_pkg::CFG_W-1:0]   wr_data,
	output rtmcw_pkg::window_t            win
);
	import rtmcw_pkg::*;

	window_t win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.red_low    <= '0;
			win_q.red_high   <= '1;
			win_q.green_low  <= '0;
			win_q.green_high <= '1;
			win_q.blue_low   <= '0;
			win_q.blue_high  <= '1;
		end else if (wr_en) begin
			case (wr_index)
				REG_RED_LOW:    win_q.red_low    <= wr_data;
				REG_RED_HIGH:   win_q.red_high   <= wr_data;
				REG_GREEN_LOW:  win_q.green_low  <= wr_data;
				REG_GREEN_HIGH: win_q.green_high <= wr_data;
				REG_BLUE_LOW:   win_q.blue_low   <= wr_data;
				REG_BLUE_HIGH:  win_q.blue_high  <= wr_data;
				default: ;      // unmapped index, dropped
			endcase
		end
	end

	assign win = win_q;

	a_unmapped_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (wr_index > REG_BLUE_HIGH)) |=> $stable(win_q))
		else $error("write to unmapped index changed window registers");

	a_no_write_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(win_q))
		else $error("window registers changed without a write");

	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_index == REG_BLUE_HIGH) |=> (win_q.blue_high == $past(wr_data)))
		else $error("blue upper bound write lost");

endmodule

>>> rtl/rtmcw_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmcw_accum
// Sample input register, position counters and per-channel sum/min/max.
// ----------------------------------------------------------------------------
module rtmcw_accum #(
	parameter int PULSE_BITS = rtmcw_pkg::PULSE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_accept,
	input  logic [PULSE_BITS-1:0]    sample,
	output rtmcw_pkg::acc_stat_t     stat,
	output logic                     valid_s2,
	output rtmcw_pkg::chan_t         chan_s2,
	output logic [PULSE_BITS+3:0]    sum_s2,
	output logic [PULSE_BITS-1:0]    min_s2,
	output logic [PULSE_BITS-1:0]    max_s2
);
	import rtmcw_pkg::*;

	localparam int SUM_W = PULSE_BITS + 4;
	localparam logic [SMP_W-1:0] SMP_LAST = SMP_W'(SAMPLES_PER_CH - 1);

	logic [SMP_W-1:0]      smp_q;
	chan_t                 chan_q;
	chan_t                 chan_nxt;

	logic                  valid_s1;
	logic                  last_s1;
	chan_t                 chan_s1;
	logic [PULSE_BITS-1:0] sample_s1;

	logic [SUM_W-1:0]      sum_q;
	logic [PULSE_BITS-1:0] min_q;
	logic [PULSE_BITS-1:0] max_q;
	logic [SUM_W-1:0]      sum_nxt;
	logic [PULSE_BITS-1:0] min_nxt;
	logic [PULSE_BITS-1:0] max_nxt;

	always_comb begin
		case (chan_q)
			CH_RED:   chan_nxt = CH_GREEN;
			CH_GREEN: chan_nxt = CH_BLUE;
			default:  chan_nxt = CH_RED;
		endcase
	end

	// position counters and input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q    <= '0;
			chan_q   <= CH_RED;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
			if (in_accept) begin
				if (smp_q == SMP_LAST) begin
					smp_q  <= '0;
					chan_q <= chan_nxt;
				end else begin
					smp_q <= smp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_s1 <= sample;
			last_s1   <= (smp_q == SMP_LAST);
			chan_s1   <= chan_q;
		end
	end

	// zero in the min register means empty
	always_comb begin
		sum_nxt = sum_q + SUM_W'(sample_s1);
		min_nxt = (min_q == '0 || sample_s1 < min_q) ? sample_s1 : min_q;
		max_nxt = (sample_s1 > max_q) ? sample_s1 : max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			min_q    <= '0;
			max_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && last_s1;
			if (valid_s1) begin
				if (last_s1) begin
					sum_q <= '0;
					min_q <= '0;
					max_q <= '0;
				end else begin
					sum_q <= sum_nxt;
					min_q <= min_nxt;
					max_q <= max_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			sum_s2  <= sum_nxt;
			min_s2  <= min_nxt;
			max_s2  <= max_nxt;
			chan_s2 <= chan_s1;
		end
	end

	assign stat.at_frame_end = (chan_q == CH_BLUE) && (smp_q == SMP_LAST);
	assign stat.blue_busy    = (valid_s1 && last_s1 && chan_s1 == CH_BLUE) ||
	                           (valid_s2 && chan_s2 == CH_BLUE);

	a_smp_range: assert property (@(posedge clk) disable iff (!arst_n)
		smp_q <= SMP_LAST)
		else $error("sample counter out of range");

	a_chan_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && stat.at_frame_end) |=> (chan_q == CH_RED && smp_q == '0))
		else $error("frame did not wrap to red");

	a_accum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (sum_q == '0 && min_q == '0 && max_q == '0))
		else $error("channel accumulators not cleared at channel end");

endmodule

>>> rtl/rtmcw_avg_win.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmcw_avg_win
// Trimmed average, red/green hold registers, window compare, result register.
// ----------------------------------------------------------------------------
module rtmcw_avg_win #(
	parameter int PULSE_BITS = rtmcw_pkg::PULSE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_s2,
	input  rtmcw_pkg::chan_t                   chan_s2,
	input  logic [PULSE_BITS+3:0]              sum_s2,
	input  logic [PULSE_BITS-1:0]              min_s2,
	input  logic [PULSE_BITS-1:0]              max_s2,
	input  rtmcw_pkg::window_t                 win,
	output logic                               busy,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rtmcw_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import rtmcw_pkg::*;

	localparam int AVG_W = PULSE_BITS + 5;
	localparam int PAD_W = OUT_TDATA_W - 3 * OUT_W - 1;
	localparam logic signed [AVG_W-1:0] ROUND_ADJ = AVG_W'((1 << TRIM_SHIFT) - 1);

	logic signed [AVG_W-1:0] trim;
	logic signed [AVG_W-1:0] trim_adj;
	logic signed [AVG_W-1:0] avg_s3;
	chan_t                   chan_s3;
	logic                    valid_s3;
	logic signed [AVG_W-1:0] red_q;
	logic signed [AVG_W-1:0] green_q;

	logic                    load;
	logic                    red_ok;
	logic                    green_ok;
	logic                    blue_ok;

	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        red_out_q;
	logic [OUT_W-1:0]        green_out_q;
	logic [OUT_W-1:0]        blue_out_q;
	logic                    match_q;

	// sum - min - max, then divide by 8 rounding toward zero
	always_comb begin
		trim = $signed({1'b0, sum_s2}) - $signed(AVG_W'(min_s2)) - $signed(AVG_W'(max_s2));
		trim_adj = trim[AVG_W-1] ? (trim + ROUND_ADJ) : trim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			avg_s3  <= trim_adj >>> TRIM_SHIFT;
			chan_s3 <= chan_s2;
		end
		if (valid_s3 && chan_s3 == CH_RED)
			red_q <= avg_s3;
		if (valid_s3 && chan_s3 == CH_GREEN)
			green_q <= avg_s3;
	end

	assign load = valid_s3 && (chan_s3 == CH_BLUE);

	always_comb begin
		red_ok   = (red_q >= $signed({1'b0, win.red_low})) &&
		           (red_q <= $signed({1'b0, win.red_high}));
		green_ok = (green_q >= $signed({1'b0, win.green_low})) &&
		           (green_q <= $signed({1'b0, win.green_high}));
		blue_ok  = (avg_s3 >= $signed({1'b0, win.blue_low})) &&
		           (avg_s3 <= $signed({1'b0, win.blue_high}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= load || (m_tvalid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_out_q   <= OUT_W'(red_q);
			green_out_q <= OUT_W'(green_q);
			blue_out_q  <= OUT_W'(avg_s3);
			match_q     <= red_ok && green_ok && blue_ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {PAD_W'(0), match_q, blue_out_q, green_out_q, red_out_q};
	assign busy     = (valid_s3 && chan_s3 == CH_BLUE) || m_tvalid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten before it was taken");

	a_single_stage_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s2 && chan_s2 == CH_BLUE && valid_s3 && chan_s3 == CH_BLUE))
		else $error("two blue channel closes in flight");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("blue channel close produced no result");

endmodule

>>> rtl/rgb_trimmed_mean_color_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_trimmed_mean_color_window_core
// Ten-sample trimmed mean per color channel with inclusive window match flag.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Content
//  s_*       in   s_tvalid/s_tready    tdata: pulse_width [PULSE_BITS-1:0]
//  m_*       out  m_tvalid/m_tready    tdata: red_average, green_average,
//                                        blue_average, color_match
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index selects a window bound,
//                                        cfg_data is the 16-bit bound
//
//  One sample per cycle sustained, bar the stall below. A frame is 30
//  samples: 10 red, 10 green, 10 blue; one result request follows the last
//  blue sample through input reg, channel totals, average and result reg.
//  s_tready drops only on the last sample of a frame while the previous
//  frame's result is still unaccepted or in flight; a waiting result does
//  not block the first 29 samples of the next frame.
//  arst_n clears counters, accumulators, valid flags and sets the windows
//  wide open (low 0, high 65535). cfg_ready is always high; unmapped
//  indices are dropped.
//
module rgb_trimmed_mean_color_window_core #(
	parameter int PULSE_BITS = rtmcw_pkg::PULSE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [PULSE_BITS-1:0] pulse_width, rest padding
	input  logic [((PULSE_BITS + 7) / 8) * 8 - 1:0] s_tdata,

	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [16:0] red_average, [33:17] green_average, [50:34] blue_average,
	// [51] color_match, [55:52] zero
	output logic [rtmcw_pkg::OUT_TDATA_W-1:0]      m_tdata,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rtmcw_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rtmcw_pkg::CFG_W-1:0]            cfg_data
);
	import rtmcw_pkg::*;

	acc_stat_t             acc_stat;
	window_t               win;
	logic                  in_accept;
	logic                  win_busy;

	logic                  valid_s2;
	chan_t                 chan_s2;
	logic [PULSE_BITS+3:0] sum_s2;
	logic [PULSE_BITS-1:0] min_s2;
	logic [PULSE_BITS-1:0] max_s2;

	// hold only the frame-closing sample while a result still occupies the back end
	assign s_tready  = !(acc_stat.at_frame_end && (acc_stat.blue_busy || win_busy));
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	rtmcw_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.win      (win)
	);

	rtmcw_accum #(
		.PULSE_BITS (PULSE_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.sample    (s_tdata[PULSE_BITS-1:0]),
		.stat      (acc_stat),
		.valid_s2  (valid_s2),
		.chan_s2   (chan_s2),
		.sum_s2    (sum_s2),
		.min_s2    (min_s2),
		.max_s2    (max_s2)
	);

	rtmcw_avg_win #(
		.PULSE_BITS (PULSE_BITS)
	) u_avg_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.chan_s2  (chan_s2),
		.sum_s2   (sum_s2),
		.min_s2   (min_s2),
		.max_s2   (max_s2),
		.win      (win),
		.busy     (win_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_stall_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> acc_stat.at_frame_end)
		else $error("input stalled away from frame end");

	a_result_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && acc_stat.at_frame_end) |-> ##4 m_tvalid)
		else $error("no result four cycles after frame close");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

>>> dv/tb_rgb_trimmed_mean_color_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_trimmed_mean_color_window_core
// Self-checking bench for the RGB trimmed-mean color window core.
//
// Pulse widths go in as 30-sample frames (ten red, ten green, ten blue). A
// behavioral color average tracker in the bench mirrors the core's
// accumulators and window registers and queues the expected averages and
// match flag at every frame close. The output monitor compares each result
// request field by field against the oldest entry. A table of directed
// frames (reset windows, full-scale and zero samples, the most negative
// average, point, empty and extreme windows, dropped register indices)
// comes first. Random frames follow in phases, each with freshly programmed
// windows: the first with a steady source and one long output hold, the
// middle ones with random idling on both streams, the last with none.
// ----------------------------------------------------------------------------
module tb_rgb_trimmed_mean_color_window_core;

	import rtmcw_pkg::*;

	localparam int S_TDATA_W        = ((PULSE_BITS_DEF + 7) / 8) * 8;
	localparam int FRAME_LEN        = 3 * SAMPLES_PER_CH;
	localparam int TRIM_DIV         = 1 << TRIM_SHIFT;
	localparam int PAD_W            = OUT_TDATA_W - 3 * OUT_W - 1;
	localparam int SETTLE_CYCLES    = 12;
	localparam int LONG_HOLD        = 200;   // > two frames of input
	localparam int N_PHASES         = 4;
	localparam int FRAMES_PER_PHASE = 4;
	localparam int LIMIT_CYCLES     = 200000;

	// indices the core has no register for; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// result request layout, lowest field last
	typedef struct packed {
		logic [PAD_W-1:0] pad;
		logic             color_match;
		logic [OUT_W-1:0] blue_average;
		logic [OUT_W-1:0] green_average;
		logic [OUT_W-1:0] red_average;
	} color_result_t;

	typedef enum {PAT_NARROW, PAT_FULL, PAT_ZEROS, PAT_EDGE} pulse_pattern_t;

	// one directed frame: each channel is nine fill samples then a closing one
	typedef struct packed {
		bit          reprogram;
		window_t     bounds;
		logic [15:0] fill_r, fill_g, fill_b;
		logic [15:0] last_r, last_g, last_b;
		bit          typed;
		int          exp_r, exp_g, exp_b;
		bit          exp_match;
	} dir_frame_t;

	localparam window_t WIN_OPEN  = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
	localparam window_t WIN_POINT = '{16'd100, 16'd100, 16'd200, 16'd200, 16'd300, 16'd300};
	localparam window_t WIN_R_MT  = '{16'd100, 16'd99, 16'd200, 16'd200, 16'd300, 16'd300};
	localparam window_t WIN_TOP   = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'hFFFF};
	localparam window_t WIN_ZERO  = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
	localparam window_t WIN_SHUT  = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};

	localparam dir_frame_t DIRECTED [9] = '{
		// reset windows, full-scale samples
		'{1'b0, WIN_OPEN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 65535, 65535, 65535, 1'b1},
		// all zero samples, spare indices written with junk
		'{1'b1, WIN_OPEN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			1'b1, 0, 0, 0, 1'b1},
		// zero minimum is replaced by the closing sample: most negative average
		'{1'b0, WIN_OPEN, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, -8191, -8191, -8191, 1'b0},
		// single-point windows, bounds inclusive
		'{1'b1, WIN_POINT, 16'd100, 16'd200, 16'd300, 16'd100, 16'd200, 16'd300,
			1'b1, 100, 200, 300, 1'b1},
		// red low above red high
		'{1'b1, WIN_R_MT, 16'd100, 16'd200, 16'd300, 16'd100, 16'd200, 16'd300,
			1'b1, 100, 200, 300, 1'b0},
		'{1'b1, WIN_TOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 65535, 65535, 65535, 1'b1},
		'{1'b1, WIN_ZERO, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			1'b1, 0, 0, 0, 1'b1},
		'{1'b1, WIN_SHUT, 16'd1000, 16'd1000, 16'd1000, 16'd3, 16'd3, 16'd3,
			1'b0, 0, 0, 0, 1'b0},
		'{1'b1, WIN_OPEN, 16'd5000, 16'd7, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1,
			1'b0, 0, 0, 0, 1'b0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;     // [15:0] pulse_width
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;     // red, green, blue average, color_match
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	// color average tracker state
	logic [4:0]  frame_pos;
	logic [19:0] chan_sum;
	logic [15:0] chan_min;               // zero means empty
	logic [15:0] chan_max;
	int          red_avg_q;
	int          green_avg_q;
	window_t     win;

	color_result_t results_due [$];
	int            mismatches;
	int            cycle_count;
	bit            src_gaps;
	bit            sink_gaps;
	bit            long_hold_req;

	rgb_trimmed_mean_color_window_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] clamp16(input int v);
		if (v < 0)
			return 16'd0;
		if (v > 65535)
			return 16'hFFFF;
		return v[15:0];
	endfunction

	function automatic bit in_window(input int avg, input logic [15:0] lo,
			input logic [15:0] hi);
		return avg >= int'(lo) && avg <= int'(hi);
	endfunction

	// Accumulate one pulse width; on the thirtieth sample of a frame return
	// the three averages and the match flag.
	task automatic apply_pulse(input logic [15:0] w, output bit done,
			output color_result_t res);
		int         avg;
		logic [4:0] pos;
		done = 1'b0;
		res  = '0;
		if (chan_min == 16'd0 || w < chan_min)
			chan_min = w;
		if (w > chan_max)
			chan_max = w;
		chan_sum = chan_sum + w;
		pos = frame_pos;
		frame_pos = (int'(frame_pos) == FRAME_LEN - 1) ? 5'd0 : frame_pos + 5'd1;
		if ((int'(pos) + 1) % SAMPLES_PER_CH == 0) begin
			// int division truncates toward zero, as the core does
			avg = (int'(chan_sum) - int'(chan_min) - int'(chan_max)) / TRIM_DIV;
			chan_sum = '0;
			chan_min = '0;
			chan_max = '0;
			case (chan_t'(pos / SAMPLES_PER_CH))
				CH_RED:   red_avg_q = avg;
				CH_GREEN: green_avg_q = avg;
				default: begin
					done = 1'b1;
					res.red_average   = red_avg_q[OUT_W-1:0];
					res.green_average = green_avg_q[OUT_W-1:0];
					res.blue_average  = avg[OUT_W-1:0];
					res.color_match   = in_window(red_avg_q, win.red_low, win.red_high) &&
						in_window(green_avg_q, win.green_low, win.green_high) &&
						in_window(avg, win.blue_low, win.blue_high);
				end
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	task automatic check_result(input color_result_t got);
		color_result_t want;
		if (results_due.size() == 0) begin
			report_mismatch("result with none due", 0, int'($signed(got.red_average)));
		end else begin
			want = results_due.pop_front();
			if (got.red_average !== want.red_average)
				report_mismatch("red_average", int'($signed(want.red_average)),
					int'($signed(got.red_average)));
			if (got.green_average !== want.green_average)
				report_mismatch("green_average", int'($signed(want.green_average)),
					int'($signed(got.green_average)));
			if (got.blue_average !== want.blue_average)
				report_mismatch("blue_average", int'($signed(want.blue_average)),
					int'($signed(got.blue_average)));
			if (got.color_match !== want.color_match)
				report_mismatch("color_match", want.color_match, got.color_match);
			if (got.pad !== want.pad)
				report_mismatch("padding", 0, got.pad);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(color_result_t'(m_tdata));
	end

	// Result side: random stall bursts, plus one long hold on request so the
	// core backs up into its input.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				m_tready = 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				m_tready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready = 1'b0;
			end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 15);
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// All driver tasks start and end just after a falling edge.
	task automatic send_pulse(input logic [15:0] w, input bit typed_on,
			input color_result_t typed);
		bit            done;
		color_result_t res;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			s_tdata  = S_TDATA_W'($urandom);
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = S_TDATA_W'(w);
		do
			@(posedge clk);
		while (!s_tready);
		apply_pulse(w, done, res);
		if (done)
			results_due.push_back(typed_on ? typed : res);
		@(negedge clk);
	endtask

	task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (cfg_reg_t'(idx))
			REG_RED_LOW:    win.red_low    = val;
			REG_RED_HIGH:   win.red_high   = val;
			REG_GREEN_LOW:  win.green_low  = val;
			REG_GREEN_HIGH: win.green_high = val;
			REG_BLUE_LOW:   win.blue_low   = val;
			REG_BLUE_HIGH:  win.blue_high  = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic program_windows(input window_t w);
		write_bound(REG_RED_LOW, w.red_low);
		write_bound(REG_RED_HIGH, w.red_high);
		write_bound(REG_GREEN_LOW, w.green_low);
		write_bound(REG_GREEN_HIGH, w.green_high);
		write_bound(REG_BLUE_LOW, w.blue_low);
		write_bound(REG_BLUE_HIGH, w.blue_high);
		write_bound(REG_SPARE_A, 16'($urandom));
		write_bound(REG_SPARE_B, 16'($urandom));
	endtask

	// Stop offering samples, wait for every due result, then let the
	// pipeline empty before touching the window registers.
	task automatic settle();
		s_tvalid = 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic void pick_window(input int center, output logic [15:0] lo,
			output logic [15:0] hi);
		int reach;
		reach = $urandom_range(0, 40);
		case ($urandom_range(0, 5))
			0: begin lo = 16'd0; hi = 16'hFFFF; end
			1: begin lo = clamp16(center); hi = clamp16(center); end
			2, 3: begin lo = clamp16(center - reach); hi = clamp16(center + reach); end
			4: begin
				// empty window
				lo = 16'($urandom_range(1, 65535));
				hi = 16'($urandom_range(0, int'(lo) - 1));
			end
			default: begin lo = 16'($urandom); hi = 16'($urandom); end
		endcase
	endfunction

	function automatic logic [15:0] draw_pulse(input pulse_pattern_t pat, input int center);
		case (pat)
			PAT_NARROW: return clamp16(center + int'($urandom_range(0, 32)) - 16);
			PAT_FULL:   return 16'($urandom);
			PAT_ZEROS:  return ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd0;
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'd0;
					1: return 16'd1;
					2: return 16'hFFFE;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	task automatic send_random_frame(input int centers [3]);
		pulse_pattern_t pat;
		int             roll;
		for (int ch = 0; ch < 3; ch++) begin
			roll = $urandom_range(0, 9);
			pat = (roll < 6) ? PAT_NARROW : (roll < 8) ? PAT_FULL :
				(roll == 8) ? PAT_ZEROS : PAT_EDGE;
			for (int k = 0; k < SAMPLES_PER_CH; k++)
				send_pulse(draw_pulse(pat, centers[ch]), 1'b0, '0);
		end
	endtask

	initial begin
		dir_frame_t    row;
		color_result_t typed;
		logic [15:0]   w;
		window_t       nw;
		int            centers [3];

		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		mismatches    = 0;
		cycle_count   = 0;
		src_gaps      = 1'b1;
		sink_gaps     = 1'b1;
		long_hold_req = 1'b0;
		frame_pos     = '0;
		chan_sum      = '0;
		chan_min      = '0;
		chan_max      = '0;
		red_avg_q     = 0;
		green_avg_q   = 0;
		win           = WIN_OPEN;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames
		foreach (DIRECTED[r]) begin
			row = DIRECTED[r];
			settle();
			if (row.reprogram)
				program_windows(row.bounds);
			typed = '0;
			typed.red_average   = row.exp_r[OUT_W-1:0];
			typed.green_average = row.exp_g[OUT_W-1:0];
			typed.blue_average  = row.exp_b[OUT_W-1:0];
			typed.color_match   = row.exp_match;
			for (int ch = 0; ch < 3; ch++) begin
				for (int k = 0; k < SAMPLES_PER_CH; k++) begin
					case (chan_t'(ch))
						CH_RED:   w = (k == SAMPLES_PER_CH - 1) ? row.last_r : row.fill_r;
						CH_GREEN: w = (k == SAMPLES_PER_CH - 1) ? row.last_g : row.fill_g;
						default:  w = (k == SAMPLES_PER_CH - 1) ? row.last_b : row.fill_b;
					endcase
					send_pulse(w, row.typed, typed);
				end
			end
		end

		// random phases: phase 0 has a steady source and the long output
		// hold; the last phase runs with no idling at all
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			src_gaps  = (p != 0) && (p != N_PHASES - 1);
			sink_gaps = (p != N_PHASES - 1);
			for (int ch = 0; ch < 3; ch++)
				centers[ch] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) :
					$urandom_range(0, 65535);
			nw = WIN_OPEN;
			pick_window(centers[0], nw.red_low, nw.red_high);
			pick_window(centers[1], nw.green_low, nw.green_high);
			pick_window(centers[2], nw.blue_low, nw.blue_high);
			program_windows(nw);
			if (p == 0)
				long_hold_req = 1'b1;
			repeat (FRAMES_PER_PHASE) send_random_frame(centers);
		end

		settle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/rtmcw_pkg.sv
rtl/rtmcw_cfg.sv
rtl/rtmcw_accum.sv
rtl/rtmcw_avg_win.sv
rtl/rgb_trimmed_mean_color_window_core.sv
dv/tb_rgb_trimmed_mean_color_window_core.sv
